// ===== rtl/core/lzvd_pkg.sv =====
// Shared types, constants and a helper function of the LZSS variable width decoder.
package lzvd_pkg;

  localparam int LZVD_WINDOW_DEPTH     = 65536;
  localparam int LZVD_RESULTS_PER_ITEM = 64;

  localparam int BYTE_W      = 8;
  localparam int DIST_BITS_W = 5;
  localparam int LEN_BITS_W  = 4;
  localparam int OUT_LEN_W   = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int BB_W        = 24;
  localparam int BB_CNT_W    = 5;
  localparam int FIELD_W     = 16;
  localparam int REM_W       = 9;

  localparam logic [DIST_BITS_W-1:0] DIST_BITS_RST = 5'd8;
  localparam logic [LEN_BITS_W-1:0]  LEN_BITS_RST  = 4'd4;
  localparam logic [OUT_LEN_W-1:0]   OUT_LEN_RST   = 24'd65536;
  localparam logic [DIST_BITS_W-1:0] DIST_BITS_MAX = 5'd16;
  localparam logic [LEN_BITS_W-1:0]  LEN_BITS_MAX  = 4'd8;

  // Room test for a new byte: the buffer takes 8 more bits at or below this fill.
  localparam logic [BB_CNT_W-1:0] BB_APPEND_MAX = 5'd16;
  localparam logic [BB_CNT_W-1:0] BB_FULL       = 5'd24;

  localparam logic [31:0] MINLEN_MUL   = 32'h38E3_8E39;
  localparam int          MINLEN_SHIFT = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIST_BITS  = 2'd0,
    REG_LEN_BITS   = 2'd1,
    REG_OUT_LENGTH = 2'd2
  } lzvd_reg_e;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_DIST,
    PH_LEN
  } lzvd_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_COPY_WR,
    ST_FINISH
  } lzvd_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              stream_done;
    logic              bad_distance;
  } lzvd_res_t;

  typedef struct packed {
    logic push;
    logic finish;
  } lzvd_os_ctl_t;

  typedef struct packed {
    logic can_push;
    logic can_finish;
    logic hold_valid;
  } lzvd_os_stat_t;

  typedef struct packed {
    logic                clear;
    logic                take;
    logic                append;
    logic [BB_CNT_W-1:0] take_n;
  } lzvd_bb_op_t;

  // Minimum copy length for the given (already limited) field widths.
  function automatic logic [BYTE_W-1:0] min_length(input logic [DIST_BITS_W-1:0] dbits,
                                                  input logic [LEN_BITS_W-1:0] lbits);
    logic [5:0]  s;
    logic [37:0] p;
    s = 6'(dbits) + 6'(lbits) + 6'd1;
    p = 38'(s) * 38'(MINLEN_MUL);
    return BYTE_W'(p >> MINLEN_SHIFT) + 8'd1;
  endfunction

endpackage

// ===== rtl/core/lzvd_in_if.sv =====
// Input channel carrying one compressed word per handshake.
interface lzvd_in_if import lzvd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              new_stream;
  logic              byte_valid;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output new_stream, output byte_valid, output data_byte,
                  input ready);
  modport sink   (input valid, input new_stream, input byte_valid, input data_byte,
                  output ready);
endinterface

// ===== rtl/core/lzvd_out_if.sv =====
// Output channel carrying one decompressed word per handshake.
interface lzvd_out_if import lzvd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              stream_done;
  logic              bad_distance;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  output bad_distance, input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  input bad_distance, output ready);
endinterface

// ===== rtl/core/lzvd_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface lzvd_cfg_if import lzvd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/lzvd_history_ram.sv =====
// History window memory: one write port, one registered read port.
module lzvd_history_ram import lzvd_pkg::*; #(
  parameter int WINDOW_DEPTH = LZVD_WINDOW_DEPTH,
  localparam int AW = $clog2(WINDOW_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [WINDOW_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lzvd_bit_buf.sv =====
// MSB-first bit buffer: appends whole bytes and hands out fields of up to 16 bits.
module lzvd_bit_buf import lzvd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lzvd_bb_op_t         op_i,
  input  logic [BYTE_W-1:0]   byte_i,
  output logic [BB_CNT_W-1:0] count_o,
  output logic [FIELD_W-1:0]  take_val_o
);

  logic [BB_W-1:0]     bb_q, bb_d;
  logic [BB_CNT_W-1:0] cnt_q, cnt_d;
  logic [BB_CNT_W-1:0] rest;
  logic [BB_W-1:0]     shifted;
  logic [FIELD_W:0]    field_mask;
  logic [BB_W:0]       rest_mask;

  always_comb begin
    rest       = cnt_q - op_i.take_n;
    shifted    = bb_q >> rest;
    field_mask = (17'd1 << op_i.take_n) - 17'd1;
    rest_mask  = (25'd1 << rest) - 25'd1;
    take_val_o = shifted[FIELD_W-1:0] & field_mask[FIELD_W-1:0];

    bb_d  = bb_q;
    cnt_d = cnt_q;
    if (op_i.clear) begin
      bb_d  = '0;
      cnt_d = '0;
    end else if (op_i.take) begin
      bb_d  = bb_q & rest_mask[BB_W-1:0];
      cnt_d = rest;
    end else if (op_i.append) begin
      bb_d  = {bb_q[BB_W-BYTE_W-1:0], byte_i};
      cnt_d = cnt_q + 5'd8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bb_q  <= '0;
      cnt_q <= '0;
    end else begin
      bb_q  <= bb_d;
      cnt_q <= cnt_d;
    end
  end

  assign count_o = cnt_q;

endmodule

// ===== rtl/core/lzvd_out_stage.sv =====
// Result staging: one word is held back until it is known whether it ends its item.
module lzvd_out_stage import lzvd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lzvd_os_ctl_t  ctl_i,
  input  lzvd_res_t     res_i,
  output lzvd_os_stat_t stat_o,
  lzvd_out_if.source    out_o
);

  lzvd_res_t hold_q;
  logic      hold_v_q;
  lzvd_res_t out_q;
  logic      out_last_q;
  logic      out_v_q;
  logic      out_free;

  assign out_free          = !out_v_q || out_o.ready;
  assign stat_o.can_push   = !hold_v_q || out_free;
  assign stat_o.can_finish = !hold_v_q || out_free;
  assign stat_o.hold_valid = hold_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (ctl_i.push && stat_o.can_push) begin
        hold_v_q <= 1'b1;
        if (hold_v_q) begin
          out_v_q <= 1'b1;
        end else if (out_o.ready) begin
          out_v_q <= 1'b0;
        end
      end else if (ctl_i.finish && hold_v_q && out_free) begin
        hold_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push && stat_o.can_push) begin
      hold_q <= res_i;
      if (hold_v_q) begin
        out_q      <= hold_q;
        out_last_q <= 1'b0;
      end
    end else if (ctl_i.finish && hold_v_q && out_free) begin
      out_q      <= hold_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.out_byte     = out_q.out_byte;
  assign out_o.run_last     = out_last_q;
  assign out_o.stream_done  = out_q.stream_done;
  assign out_o.bad_distance = out_q.bad_distance;

endmodule

// ===== rtl/core/lzss_variable_width_decoder.sv =====
// LZSS decoder with configurable copy field widths, built around a history memory.
//
// Channels: in_i takes one word per accepted handshake: new_stream clears the bit
// buffer, the pending copy and the output count first; byte_valid says whether
// data_byte is a compressed byte or the word only lets a long copy continue.
// out_o gives one decompressed byte per word; run_last marks the last word caused
// by an input word, stream_done marks byte number out_length, bad_distance marks
// a copy whose distance was zero or reached past the bytes produced (byte is 0).
// cfg_i writes dist_bits, len_bits and out_length; it is always ready.
// Sequencing: decode steps (flag, literal, distance, length, byte append) run in
// ST_STEP; a copied byte takes a memory read, then write back and emit; a flagged
// byte is emitted from ST_STEP; closing a word takes the step that finds nothing
// left, then the hand-over of the held result in ST_FINISH, and ST_IDLE accepts the
// next word. No new word is taken while the last one is still being decoded. At most
// RESULTS_PER_ITEM bytes come from one word; a longer copy goes on over later words.
// The last result of a word is held one stage until the word's end is known; the
// next input word is accepted while that result still waits in the output register.
// Reset clears all control state and the registers to their defaults; the history
// memory is not cleared, since only bytes written in the current stream are read.
// When the receiver stalls, decoding halts at the next byte to be emitted.
module lzss_variable_width_decoder import lzvd_pkg::*; #(
  parameter int WINDOW_DEPTH     = LZVD_WINDOW_DEPTH,
  parameter int RESULTS_PER_ITEM = LZVD_RESULTS_PER_ITEM
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lzvd_in_if.sink    in_i,
  lzvd_out_if.source out_o,
  lzvd_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int NW = $clog2(RESULTS_PER_ITEM + 1);
  localparam int CW = 18;  // wide enough for a signed window index difference

  // Configuration registers.
  logic [DIST_BITS_W-1:0] dist_bits_q;
  logic [LEN_BITS_W-1:0]  len_bits_q;
  logic [OUT_LEN_W-1:0]   out_length_q;

  // Decoder state.
  lzvd_state_e          state_q, state_d;
  lzvd_phase_e          phase_q, phase_d;
  logic [FIELD_W-1:0]   dist_q, dist_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [OUT_LEN_W-1:0] produced_q, produced_d;
  logic [AW-1:0]        wptr_q, wptr_d;
  logic [NW-1:0]        n_q, n_d;
  logic                 pend_q, pend_d;
  logic [BYTE_W-1:0]    byte_q, byte_d;

  logic [DIST_BITS_W-1:0] eff_dist;
  logic [LEN_BITS_W-1:0]  eff_len;
  logic [BB_CNT_W-1:0]    need;
  logic                   done;
  logic                   stop;
  logic                   copy_bad;
  logic [CW-1:0]          rd_diff;
  logic [CW-1:0]          rd_idx;

  logic              emit_req;
  logic              emit_fire;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_bad;
  logic              rd_en;

  lzvd_bb_op_t         bb_op;
  logic [BB_CNT_W-1:0] bb_count;
  logic [FIELD_W-1:0]  bb_val;
  logic [BYTE_W-1:0]   bb_byte;

  lzvd_os_ctl_t  os_ctl;
  lzvd_os_stat_t os_stat;
  lzvd_res_t     os_res;
  logic [BYTE_W-1:0] rdata;

  logic in_acc;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_bits_q  <= DIST_BITS_RST;
      len_bits_q   <= LEN_BITS_RST;
      out_length_q <= OUT_LEN_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_DIST_BITS:  dist_bits_q  <= cfg_i.data[DIST_BITS_W-1:0];
        REG_LEN_BITS:   len_bits_q   <= cfg_i.data[LEN_BITS_W-1:0];
        REG_OUT_LENGTH: out_length_q <= cfg_i.data[OUT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Field widths above their limits act as the limit.
  assign eff_dist = (dist_bits_q > DIST_BITS_MAX) ? DIST_BITS_MAX : dist_bits_q;
  assign eff_len  = (len_bits_q > LEN_BITS_MAX) ? LEN_BITS_MAX : len_bits_q;

  always_comb begin
    unique case (phase_q)
      PH_FLAG: need = 5'd1;
      PH_LIT:  need = 5'd8;
      PH_DIST: need = eff_dist;
      PH_LEN:  need = BB_CNT_W'(eff_len);
      default: need = 5'd1;
    endcase
  end

  assign done = (produced_q == out_length_q);
  assign stop = (n_q == NW'(RESULTS_PER_ITEM)) || done;

  assign copy_bad = (dist_q == '0) || (OUT_LEN_W'(dist_q) > produced_q) ||
                    (17'(dist_q) > 17'(WINDOW_DEPTH));

  // The write pointer tracks produced_q modulo the window, so the source of a
  // copy is the write pointer minus the distance, wrapped once.
  assign rd_diff = CW'(wptr_q) - CW'(dist_q);
  assign rd_idx  = rd_diff[CW-1] ? rd_diff + CW'(WINDOW_DEPTH) : rd_diff;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    dist_d     = dist_q;
    rem_d      = rem_q;
    n_d        = n_q;
    pend_d     = pend_q;
    byte_d     = byte_q;
    produced_d = produced_q;
    wptr_d     = wptr_q;
    emit_req   = 1'b0;
    emit_byte  = '0;
    emit_bad   = 1'b0;
    rd_en      = 1'b0;
    bb_op      = '{clear: 1'b0, take: 1'b0, append: 1'b0, take_n: need};
    bb_byte    = byte_q;
    os_ctl     = '{push: 1'b0, finish: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pend_d  = in_i.byte_valid;
          byte_d  = in_i.data_byte;
          n_d     = '0;
          state_d = ST_STEP;
          if (in_i.new_stream) begin
            bb_op.clear = 1'b1;
            phase_d     = PH_FLAG;
            dist_d      = '0;
            rem_d       = '0;
            produced_d  = '0;
            wptr_d      = '0;
          end
        end
      end

      ST_STEP: begin
        priority if (stop) begin
          // A finished stream drops whatever copy is still pending.
          if (done) begin
            rem_d = '0;
          end
          state_d = ST_FINISH;
        end else if (rem_q != '0) begin
          if (copy_bad) begin
            emit_req = 1'b1;
            emit_bad = 1'b1;
            if (os_stat.can_push) begin
              rem_d = rem_q - 9'd1;
            end
          end else begin
            rd_en   = 1'b1;
            state_d = ST_COPY_WR;
          end
        end else if (bb_count >= need) begin
          unique case (phase_q)
            PH_FLAG: begin
              bb_op.take = 1'b1;
              phase_d    = bb_val[0] ? PH_LIT : PH_DIST;
            end
            PH_LIT: begin
              emit_req  = 1'b1;
              emit_byte = bb_val[BYTE_W-1:0];
              if (os_stat.can_push) begin
                bb_op.take = 1'b1;
                phase_d    = PH_FLAG;
              end
            end
            PH_DIST: begin
              bb_op.take = 1'b1;
              dist_d     = bb_val;
              phase_d    = PH_LEN;
            end
            PH_LEN: begin
              bb_op.take = 1'b1;
              rem_d      = REM_W'(bb_val[BYTE_W-1:0]) + REM_W'(min_length(eff_dist, eff_len));
              phase_d    = PH_FLAG;
            end
            default: ;
          endcase
        end else if (pend_q && bb_count <= BB_APPEND_MAX) begin
          bb_op.append = 1'b1;
          pend_d       = 1'b0;
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_COPY_WR: begin
        emit_req  = 1'b1;
        emit_byte = rdata;
        if (os_stat.can_push) begin
          rem_d   = rem_q - 9'd1;
          state_d = ST_STEP;
        end
      end

      ST_FINISH: begin
        // A byte that found no room during decoding gets its last chance here.
        if (pend_q && bb_count <= BB_APPEND_MAX) begin
          bb_op.append = 1'b1;
          pend_d       = 1'b0;
        end
        os_ctl.finish = 1'b1;
        if (os_stat.can_finish) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // Emitting a byte writes it to history and advances the counters.
    emit_fire   = emit_req && os_stat.can_push;
    os_ctl.push = emit_fire;
    if (emit_fire) begin
      produced_d = produced_q + 24'd1;
      n_d        = n_q + NW'(1);
      if (produced_q == '1 || wptr_q == AW'(WINDOW_DEPTH - 1)) begin
        wptr_d = '0;
      end else begin
        wptr_d = wptr_q + AW'(1);
      end
    end
  end

  assign os_res = '{out_byte:     emit_byte,
                    stream_done:  (produced_q + 24'd1) == out_length_q,
                    bad_distance: emit_bad};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_FLAG;
      dist_q     <= '0;
      rem_q      <= '0;
      produced_q <= '0;
      wptr_q     <= '0;
      n_q        <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      dist_q     <= dist_d;
      rem_q      <= rem_d;
      produced_q <= produced_d;
      wptr_q     <= wptr_d;
      n_q        <= n_d;
      pend_q     <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  lzvd_history_ram #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (emit_fire),
    .waddr_i(wptr_q),
    .wdata_i(emit_byte),
    .re_i   (rd_en),
    .raddr_i(rd_idx[AW-1:0]),
    .rdata_o(rdata)
  );

  lzvd_bit_buf u_bit_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (bb_op),
    .byte_i    (bb_byte),
    .count_o   (bb_count),
    .take_val_o(bb_val)
  );

  lzvd_out_stage u_out_stage (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (os_ctl),
    .res_i (os_res),
    .stat_o(os_stat),
    .out_o (out_o)
  );

  // A new input word only starts once every result of the previous one has left
  // the holding stage.
  a_accept_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !os_stat.hold_valid)
    else $error("input word accepted while a result is still held");

  a_bits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bb_count <= BB_FULL)
    else $error("bit buffer overfilled");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_distance |-> out_o.out_byte == '0)
    else $error("flagged copy byte is not zero");

  a_results_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(RESULTS_PER_ITEM))
    else $error("too many results for one input word");

  a_copy_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COPY_WR |-> rem_q != '0)
    else $error("copy write-back without a pending copy");

endmodule

// ===== dv/lzss_variable_width_decoder_tb.sv =====
// Self-checking testbench for the LZSS variable width decoder.
module lzss_variable_width_decoder_tb;
  import lzvd_pkg::*;

  // One word on the input channel and one word on the output channel.
  typedef struct packed {
    logic              new_stream;
    logic              byte_valid;
    logic [BYTE_W-1:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              stream_done;
    logic              bad_distance;
  } out_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lzvd_in_if  in_if ();
  lzvd_out_if out_if ();
  lzvd_cfg_if cfg_if ();

  lzss_variable_width_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Compressed words waiting for the driver, and decompressed words the model says are due.
  in_word_t  compressed_words[$];
  out_word_t due_bytes[$];

  // Decoder model: history window, bit buffer, decode position and the register copies.
  logic [BYTE_W-1:0]      hist_mem [LZVD_WINDOW_DEPTH];
  int unsigned            bitbuf;
  int unsigned            bitbuf_cnt;
  lzvd_phase_e            dec_phase;
  logic [FIELD_W-1:0]     copy_dist;
  logic [REM_W-1:0]       copy_left;
  logic [OUT_LEN_W-1:0]   made_cnt;
  logic [DIST_BITS_W-1:0] cfg_dist_bits;
  logic [LEN_BITS_W-1:0]  cfg_len_bits;
  logic [OUT_LEN_W-1:0]   cfg_out_len;

  // Bit-level encoder used to build compressed streams, with the bytes each command yields
  // noted on its last bit.
  bit          code_bits[$];
  int unsigned code_yield[$];

  in_word_t    on_bus;
  bit          bus_busy;
  int unsigned in_gap, in_calm, out_gap, out_calm;
  int unsigned words_queued;
  int          fail_cnt;
  out_word_t   seen, want;

  // Field widths above the supported maximum behave as the maximum.
  function automatic int unsigned dist_width();
    return (cfg_dist_bits > DIST_BITS_MAX) ? DIST_BITS_MAX : cfg_dist_bits;
  endfunction

  function automatic int unsigned len_width();
    return (cfg_len_bits > LEN_BITS_MAX) ? LEN_BITS_MAX : cfg_len_bits;
  endfunction

  // Shortest copy worth a command: about (field bits + 1) / 9, plus one.
  function automatic logic [7:0] min_copy_len();
    longint unsigned s;
    s = dist_width() + len_width() + 1;
    return 8'(((64'(MINLEN_MUL) * s) >> MINLEN_SHIFT) + 1);
  endfunction

  // Each side draws a random wait per word, with occasional stretches that never wait.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 17);
  endfunction

  task automatic restart_stream();
    bitbuf     = 0;
    bitbuf_cnt = 0;
    dec_phase  = PH_FLAG;
    copy_dist  = '0;
    copy_left  = '0;
    made_cnt   = '0;
  endtask

  // Every emitted byte also lands in the history window.
  task automatic emit_byte(input logic [7:0] b, input logic bad);
    hist_mem[made_cnt % LZVD_WINDOW_DEPTH] = b;
    made_cnt = made_cnt + 1'b1;
    due_bytes.push_back('{b, 1'b0, made_cnt == cfg_out_len, bad});
  endtask

  // Works out the decompressed words caused by one accepted compressed word.
  task automatic decompress_word(input in_word_t w);
    int          n;
    bit          pending;
    bit          busy;
    int unsigned need;
    int unsigned field;
    out_word_t   last;
    if (w.new_stream) restart_stream();
    pending = w.byte_valid;
    n = 0;
    busy = 1'b1;
    while (busy) begin
      if (n >= LZVD_RESULTS_PER_ITEM || made_cnt == cfg_out_len) begin
        // A finished stream drops whatever is left of a copy.
        if (made_cnt == cfg_out_len) copy_left = '0;
        busy = 1'b0;
      end else if (copy_left > 0) begin
        if (copy_dist == 0 || copy_dist > made_cnt || copy_dist > LZVD_WINDOW_DEPTH)
          emit_byte(8'h00, 1'b1);
        else
          emit_byte(hist_mem[(made_cnt - OUT_LEN_W'(copy_dist)) % LZVD_WINDOW_DEPTH], 1'b0);
        n++;
        copy_left--;
      end else begin
        case (dec_phase)
          PH_FLAG: need = 1;
          PH_LIT:  need = 8;
          PH_DIST: need = dist_width();
          default: need = len_width();
        endcase
        if (bitbuf_cnt >= need) begin
          field = 0;
          if (need > 0) begin
            bitbuf_cnt -= need;
            field = (bitbuf >> bitbuf_cnt) & ((32'd1 << need) - 1);
            bitbuf &= (32'd1 << bitbuf_cnt) - 1;
          end
          case (dec_phase)
            PH_FLAG: dec_phase = (field != 0) ? PH_LIT : PH_DIST;
            PH_LIT: begin
              emit_byte(8'(field), 1'b0);
              n++;
              dec_phase = PH_FLAG;
            end
            PH_DIST: begin
              copy_dist = FIELD_W'(field);
              dec_phase = PH_LEN;
            end
            default: begin
              copy_left = REM_W'(field + min_copy_len());
              dec_phase = PH_FLAG;
            end
          endcase
        end else if (pending && bitbuf_cnt <= BB_APPEND_MAX) begin
          bitbuf = ((bitbuf << 8) | w.data_byte) & 32'hFF_FFFF;
          bitbuf_cnt += 8;
          pending = 1'b0;
        end else begin
          busy = 1'b0;
        end
      end
    end
    // A byte that still finds room is kept for the next word; otherwise it is lost.
    if (pending && bitbuf_cnt <= BB_APPEND_MAX) begin
      bitbuf = ((bitbuf << 8) | w.data_byte) & 32'hFF_FFFF;
      bitbuf_cnt += 8;
    end
    if (n > 0) begin
      last = due_bytes.pop_back();
      last.run_last = 1'b1;
      due_bytes.push_back(last);
    end
  endtask

  task automatic queue_word(input bit ns, input bit bv, input logic [7:0] d);
    compressed_words.push_back('{ns, bv, d});
    if (bv) words_queued++;
  endtask

  task automatic put_bits(input int unsigned v, input int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) begin
      code_bits.push_back(v[i]);
      code_yield.push_back(0);
    end
  endtask

  task automatic put_literal(input logic [7:0] b);
    int unsigned y;
    put_bits(1, 1);
    put_bits(b, 8);
    y = code_yield.pop_back();
    code_yield.push_back(y + 1);
  endtask

  task automatic put_copy(input int unsigned d, input int unsigned lf);
    int unsigned y;
    put_bits(0, 1);
    put_bits(d, dist_width());
    put_bits(lf, len_width());
    y = code_yield.pop_back();
    code_yield.push_back(y + lf + min_copy_len());
  endtask

  // Packs the encoded bits into words, padding the tail with random bits. When per_cont is
  // nonzero, words with no byte follow so that long copies can drain before more bits arrive.
  task automatic pack_words(input bit fresh, input int unsigned per_cont);
    bit          first;
    logic [7:0]  b;
    int unsigned yield;
    first = fresh;
    while (code_bits.size() > 0) begin
      b = '0;
      yield = 0;
      for (int i = 0; i < 8; i++) begin
        if (code_bits.size() > 0) begin
          b = {b[6:0], code_bits.pop_front()};
          yield += code_yield.pop_front();
        end else begin
          b = {b[6:0], 1'($urandom_range(0, 1))};
        end
      end
      queue_word(first, 1'b1, b);
      first = 1'b0;
      if (per_cont > 0) repeat (yield / per_cont) queue_word(1'b0, 1'b0, 8'($urandom));
    end
  endtask

  // A stream of literals and copies. Most copies point inside the bytes made so far;
  // some carry an arbitrary distance. Without fresh, the stream joins the old state.
  task automatic gen_stream(input bit fresh);
    int unsigned made, top, lmax, lf;
    made = 0;
    top = (dist_width() == 0) ? 0 : ((32'd1 << dist_width()) - 1);
    lmax = (32'd1 << len_width()) - 1;
    repeat ($urandom_range(3, 12)) begin
      lf = $urandom_range(0, 1) ? $urandom_range(0, (lmax < 7) ? lmax : 7)
                                : $urandom_range(0, lmax);
      if (made > 0 && top > 0 && $urandom_range(0, 9) < 6) begin
        put_copy($urandom_range(1, (made < top) ? made : top), lf);
        made += lf + min_copy_len();
      end else if ($urandom_range(0, 5) == 0) begin
        put_copy($urandom_range(0, top), lf);
        made += lf + min_copy_len();
      end else begin
        put_literal(8'($urandom));
        made++;
      end
    end
    pack_words(fresh, 40);
  endtask

  // Registers change only while the decoder is idle, so the model takes the value at once.
  task automatic write_reg(input lzvd_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_DIST_BITS:  cfg_dist_bits = val[DIST_BITS_W-1:0];
      REG_LEN_BITS:   cfg_len_bits  = val[LEN_BITS_W-1:0];
      REG_OUT_LENGTH: cfg_out_len   = val[OUT_LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every word is sent and every due byte has arrived, then lets the decoder
  // finish any decode steps that emit nothing.
  task automatic drain();
    do @(posedge clk_i);
    while (compressed_words.size() != 0 || bus_busy || due_bytes.size() != 0);
    repeat (100) @(posedge clk_i);
  endtask

  // Driver: a word stays on the bus until taken; the model runs on the accepting edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        decompress_word(on_bus);
        bus_busy = 1'b0;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (compressed_words.size() > 0) begin
        on_bus = compressed_words.pop_front();
        bus_busy = 1'b1;
        in_if.valid      <= 1'b1;
        in_if.new_stream <= on_bus.new_stream;
        in_if.byte_valid <= on_bus.byte_valid;
        in_if.data_byte  <= on_bus.data_byte;
        in_gap = draw_gap(in_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: each accepted output word is checked against the oldest due byte.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        seen = '{out_if.out_byte, out_if.run_last, out_if.stream_done, out_if.bad_distance};
        if (due_bytes.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: word with nothing due: byte %02h last %0b done %0b bad %0b",
                     $time, seen.out_byte, seen.run_last, seen.stream_done,
                     seen.bad_distance);
        end else begin
          want = due_bytes.pop_front();
          if (seen !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display({"%0t: mismatch: expected byte %02h last %0b done %0b bad %0b, ",
                        "got byte %02h last %0b done %0b bad %0b"}, $time,
                       want.out_byte, want.run_last, want.stream_done, want.bad_distance,
                       seen.out_byte, seen.run_last, seen.stream_done, seen.bad_distance);
          end
        end
        out_gap = draw_gap(out_calm);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned phase_end, target;
    logic [CFG_DATA_W-1:0] d_val, l_val, o_val;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.new_stream = 1'b0;
    in_if.byte_valid = 1'b0;
    in_if.data_byte  = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_DIST_BITS;
    cfg_if.data      = '0;
    cfg_dist_bits    = DIST_BITS_RST;
    cfg_len_bits     = LEN_BITS_RST;
    cfg_out_len      = OUT_LEN_RST;
    restart_stream();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Narrow fields and a 20-byte stream: extreme literals, an overlapping copy, a zero
    // distance, a distance before the first byte, and a copy cut short by the stream end.
    write_reg(REG_DIST_BITS, 24'd4);
    write_reg(REG_LEN_BITS, 24'd2);
    write_reg(REG_OUT_LENGTH, 24'd20);
    put_literal(8'h00);
    put_literal(8'hFF);
    put_literal(8'hA5);
    put_copy(1, 3);
    put_copy(0, 1);
    put_copy(15, 0);
    put_copy(3, 3);
    put_literal(8'h80);
    put_copy(2, 3);
    put_copy(10, 3);
    put_literal(8'h5A);
    pack_words(1'b1, 40);
    queue_word(1'b1, 1'b0, 8'h00);
    queue_word(1'b0, 1'b0, 8'hFF);
    drain();

    // Widest fields and the longest stream: a 258-byte copy spans several words, and bytes
    // that arrive while it drains overflow the bit buffer and are dropped.
    write_reg(REG_DIST_BITS, 24'd16);
    write_reg(REG_LEN_BITS, 24'd8);
    write_reg(REG_OUT_LENGTH, 24'hFF_FFFF);
    put_literal(8'hFF);
    put_copy(1, 255);
    put_copy(16'hFFFF, 0);
    pack_words(1'b1, 0);
    queue_word(1'b0, 1'b1, 8'hFF);
    queue_word(1'b0, 1'b1, 8'hFF);
    repeat (4) queue_word(1'b0, 1'b0, 8'h00);
    drain();

    // Random phases: mostly well-formed streams, some that join a stream in progress, and
    // some raw noise words. Widths beyond the limits and an empty stream length included.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          d_val = 24'd1;
          l_val = 24'd0;
          o_val = 24'($urandom_range(30, 120));
          target = 24;
        end
        1: begin d_val = 24'd16; l_val = 24'd8;  o_val = 24'hFF_FFFF; target = 28; end
        2: begin
          d_val = 24'd0;
          l_val = 24'd15;
          o_val = 24'($urandom_range(40, 200));
          target = 20;
        end
        3: begin d_val = 24'd31; l_val = 24'd9;  o_val = 24'd0;       target = 8;  end
        4: begin
          d_val = 24'($urandom_range(1, 16));
          l_val = 24'($urandom_range(0, 8));
          o_val = 24'd1;
          target = 12;
        end
        default: begin
          d_val = 24'($urandom_range(1, 16));
          l_val = 24'($urandom_range(0, 8));
          o_val = ($urandom_range(0, 2) == 0) ? 24'hFF_FFFF : 24'($urandom_range(10, 400));
          target = 32;
        end
      endcase
      write_reg(REG_DIST_BITS, d_val);
      write_reg(REG_LEN_BITS, l_val);
      write_reg(REG_OUT_LENGTH, o_val);
      phase_end = words_queued + target;
      while (words_queued < phase_end) begin
        case ($urandom_range(0, 9))
          7: gen_stream(1'b0);
          8, 9: begin
            repeat ($urandom_range(1, 4))
              queue_word($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), 8'($urandom));
          end
          default: gen_stream(1'b1);
        endcase
      end
      drain();
    end

    if (fail_cnt == 0 && due_bytes.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Hang guard, well beyond the slowest legal run.
  initial begin
    #(8 * 2_500_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
